// ===== rtl/leading_silence_window_detector_assert.svh =====
// Assertion macros for the leading silence window detector.
`ifndef LEADING_SILENCE_WINDOW_DETECTOR_ASSERT_SVH
`define LEADING_SILENCE_WINDOW_DETECTOR_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define LSWD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define LSWD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lswd_pkg.sv =====
package lswd_pkg;

   localparam int SampleW  = 16;
   localparam int MagW     = SampleW + 1;
   localparam int SqW      = 31;          // largest square is 2**30
   localparam int SumW     = 47;
   localparam int PosW     = 16;
   localparam int CountW   = PosW + 1;
   localparam int ThrW     = 31;
   localparam int LimW     = ThrW + CountW;
   localparam int TrimW    = 32;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 32;

   localparam logic [PosW-1:0] WINDOW_LENGTH_RESET    = 16'd9600;
   localparam logic [ThrW-1:0] THRESHOLD_SQUARE_RESET = 31'd25;

   localparam logic [CsrIdxW-1:0] REG_WINDOW_LENGTH    = 1'b0;
   localparam logic [CsrIdxW-1:0] REG_THRESHOLD_SQUARE = 1'b1;

   // squared sample on its way to the accumulator
   typedef struct packed {
      logic [SqW-1:0] square;
      logic           last;
   } sq_word_type;

   typedef struct packed {
      logic [TrimW-1:0] trim_count;
      logic             loud_found;
   } rsp_word_type;

   typedef struct packed {
      logic [PosW-1:0] window_length;
      logic [ThrW-1:0] threshold_square;
      logic            thr_written;      // one-cycle pulse on a threshold write
   } cfg_type;

endpackage

// ===== rtl/lswd_if.sv =====
interface lswd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [lswd_pkg::SampleW-1:0] sample;
   logic                                last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

interface lswd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lswd_pkg::TrimW-1:0]   trim_count;
   logic                         loud_found;

   modport source (output valid, trim_count, loud_found, input ready);
   modport sink   (input valid, trim_count, loud_found, output ready);
endinterface

interface lswd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lswd_pkg::CsrIdxW-1:0]    index;
   logic [lswd_pkg::CsrDataW-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/leading_silence_window_detector.sv =====
// Leading silence window detector.
// req_ch: one signed 16-bit sample per word plus a last mark. Samples are cut
//   into windows of window_length; a window is quiet when its sum of squares
//   is below threshold_square * window_length. Quiet windows at the start of a
//   sound add to the trim count; the first loud window freezes it.
// rsp_ch: one word per sound, sent for the sample marked last: trim_count and
//   loud_found. Other samples give no word. A trailing partial window is
//   dropped and the stream state clears after the last sample.
// csr_ch: index 0 window_length (0 means 65536), index 1 threshold_square.
//   Always ready; write only with no sound in flight.
// Throughput: one sample per cycle while rsp_ch is not stalled (see below). The
//   result reaches rsp_ch through the input register, the squarer register,
//   then the accumulate step into the result register.
// The accumulate step carries a running bound (threshold times window
//   position) so each cycle needs only an add and a compare; a threshold
//   write recomputes that bound in the following cycle with one multiply.
// A stalled rsp_ch holds its word; samples keep flowing until a second last
//   sample reaches the accumulator, which then waits, and req_ch backs up.
// Reset (synchronous) clears the stream state and restores the registers to
//   9600 and 25; req_ch is not ready while reset is high.
module leading_silence_window_detector (
   input  logic        clock,
   input  logic        reset,
   lswd_req_if.sink    req_ch,
   lswd_rsp_if.source  rsp_ch,
   lswd_csr_if.sink    csr_ch
);

   logic [lswd_pkg::PosW-1:0] window_length_ff;
   logic [lswd_pkg::ThrW-1:0] threshold_square_ff;
   logic                      csr_write;
   lswd_pkg::cfg_type         cfg;

   logic                      sq_valid;
   logic                      sq_ready;
   lswd_pkg::sq_word_type     sq_word;
   lswd_pkg::rsp_word_type    rsp_word;

   // config registers
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff    <= lswd_pkg::WINDOW_LENGTH_RESET;
         threshold_square_ff <= lswd_pkg::THRESHOLD_SQUARE_RESET;
      end else if (csr_write) begin
         case (csr_ch.index)
            lswd_pkg::REG_WINDOW_LENGTH: begin
               window_length_ff <= csr_ch.data[lswd_pkg::PosW-1:0];
            end
            lswd_pkg::REG_THRESHOLD_SQUARE: begin
               threshold_square_ff <= csr_ch.data[lswd_pkg::ThrW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.window_length    = window_length_ff;
   assign cfg.threshold_square = threshold_square_ff;
   assign cfg.thr_written      = csr_write
                               && (csr_ch.index == lswd_pkg::REG_THRESHOLD_SQUARE);

   // input register and squarer
   lswd_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_sample (req_ch.sample),
      .in_last   (req_ch.last),
      .out_valid (sq_valid),
      .out_word  (sq_word),
      .out_ready (sq_ready)
   );

   // window accumulate, judge, and result register
   lswd_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (sq_valid),
      .in_word   (sq_word),
      .in_ready  (sq_ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_word  (rsp_word),
      .rsp_ready (rsp_ch.ready)
   );

   assign rsp_ch.trim_count = rsp_word.trim_count;
   assign rsp_ch.loud_found = rsp_word.loud_found;

endmodule

// ===== rtl/lswd_square.sv =====
module lswd_square (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [lswd_pkg::SampleW-1:0] in_sample,
   input  logic                                in_last,
   output logic                                out_valid,
   output lswd_pkg::sq_word_type               out_word,
   input  logic                                out_ready
);

   logic                                s1_valid_ff, s1_valid_in;
   logic signed [lswd_pkg::SampleW-1:0] s1_sample_ff;
   logic                                s1_last_ff;
   logic                                s2_valid_ff, s2_valid_in;
   lswd_pkg::sq_word_type               s2_word_ff;

   logic                                s1_move;
   logic                                s2_free;
   logic [lswd_pkg::MagW-1:0]           mag;
   logic [lswd_pkg::SqW-1:0]            mag_sq;

   assign s2_free  = !s2_valid_ff || out_ready;
   assign s1_move  = s1_valid_ff && s2_free;
   assign in_ready = !reset && (!s1_valid_ff || s1_move);

   assign s1_valid_in = (in_valid && in_ready) || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && !out_ready);

   // |sample|, -32768 maps to 32768
   always_comb begin
      if (s1_sample_ff[lswd_pkg::SampleW-1]) begin
         mag = lswd_pkg::MagW'(1 << lswd_pkg::SampleW)
             - {1'b0, s1_sample_ff};
      end else begin
         mag = {1'b0, s1_sample_ff};
      end
      // largest square is 2**30, fits SqW
      mag_sq = lswd_pkg::SqW'(mag) * lswd_pkg::SqW'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_sample_ff <= in_sample;
         s1_last_ff   <= in_last;
      end
      if (s1_move) begin
         s2_word_ff.square <= mag_sq;
         s2_word_ff.last   <= s1_last_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

// ===== rtl/lswd_accum.sv =====
module lswd_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  lswd_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   input  lswd_pkg::sq_word_type  in_word,
   output logic                   in_ready,
   output logic                   rsp_valid,
   output lswd_pkg::rsp_word_type rsp_word,
   input  logic                   rsp_ready
);

   logic [lswd_pkg::SumW-1:0]   sum_ff, sum_in;
   logic [lswd_pkg::PosW-1:0]   pos_ff, pos_in;
   logic [lswd_pkg::TrimW-1:0]  silent_ff, silent_in;
   logic                        loud_ff, loud_in;
   // threshold_square * (pos + 1), the bound for the next sample's window
   logic [lswd_pkg::LimW-1:0]   lim_ff, lim_in;
   logic                        recalc_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   lswd_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   logic                        go;
   logic [lswd_pkg::SumW-1:0]   sum_new;
   logic [lswd_pkg::CountW-1:0] count;
   logic [lswd_pkg::CountW-1:0] eff;
   logic                        closing;
   logic                        quiet;
   logic [lswd_pkg::TrimW:0]    trim_sum;
   logic [lswd_pkg::TrimW-1:0]  trim_sat;
   logic [lswd_pkg::TrimW-1:0]  silent_next;
   logic                        loud_next;
   logic [lswd_pkg::LimW-1:0]   thr_ext;
   logic [lswd_pkg::LimW-1:0]   recalc_prod;

   assign in_ready = !in_word.last || !rsp_valid_ff || rsp_ready;
   assign go       = in_valid && in_ready;

   // only used right after a threshold write, with the pipe empty
   assign recalc_prod = lswd_pkg::LimW'(cfg.threshold_square)
                      * lswd_pkg::LimW'({1'b0, pos_ff} + lswd_pkg::CountW'(1));

   always_comb begin
      sum_new  = sum_ff + lswd_pkg::SumW'(in_word.square);
      count    = {1'b0, pos_ff} + lswd_pkg::CountW'(1);
      eff      = (cfg.window_length == '0) ? lswd_pkg::CountW'(1 << lswd_pkg::PosW)
                                           : {1'b0, cfg.window_length};
      closing  = count >= eff;
      quiet    = {1'b0, sum_new} < lim_ff;
      trim_sum = {1'b0, silent_ff} + (lswd_pkg::TrimW+1)'(count);
      trim_sat = trim_sum[lswd_pkg::TrimW] ? '1 : trim_sum[lswd_pkg::TrimW-1:0];
      thr_ext  = lswd_pkg::LimW'(cfg.threshold_square);

      silent_next = silent_ff;
      loud_next   = loud_ff;
      if (closing && !loud_ff) begin
         if (quiet) begin
            silent_next = trim_sat;
         end else begin
            loud_next = 1'b1;
         end
      end

      sum_in    = sum_ff;
      pos_in    = pos_ff;
      silent_in = silent_ff;
      loud_in   = loud_ff;
      lim_in    = lim_ff;
      if (recalc_ff) begin
         lim_in = recalc_prod;
      end else if (go) begin
         if (in_word.last) begin
            sum_in    = '0;
            pos_in    = '0;
            silent_in = '0;
            loud_in   = 1'b0;
            lim_in    = thr_ext;
         end else if (closing) begin
            sum_in    = '0;
            pos_in    = '0;
            silent_in = silent_next;
            loud_in   = loud_next;
            lim_in    = thr_ext;
         end else begin
            sum_in = sum_new;
            pos_in = count[lswd_pkg::PosW-1:0];
            lim_in = lim_ff + thr_ext;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (go && in_word.last) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.trim_count = silent_next;
         rsp_word_in.loud_found = loud_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         pos_ff       <= '0;
         silent_ff    <= '0;
         loud_ff      <= 1'b0;
         lim_ff       <= lswd_pkg::LimW'(lswd_pkg::THRESHOLD_SQUARE_RESET);
         recalc_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         silent_ff    <= silent_in;
         loud_ff      <= loud_in;
         lim_ff       <= lim_in;
         recalc_ff    <= cfg.thr_written;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/lswd_checker.sv =====
`include "leading_silence_window_detector_assert.svh"

module lswd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_last,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lswd_pkg::TrimW-1:0]       rsp_trim_count,
   input logic                             rsp_loud_found
);

   `LSWD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_trim_count) && $stable(rsp_loud_found), "rsp word changed while stalled")
   `LSWD_ASSERT_NR(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp valid right after reset")
   `LSWD_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 3), "rsp word without a last sample three cycles before")
   `LSWD_ASSERT(a_req_ready_free, clock, reset, !rsp_valid |-> req_ready, "req stalled with rsp channel empty")

endmodule

bind leading_silence_window_detector lswd_checker u_lswd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_last       (req_ch.last),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_trim_count (rsp_ch.trim_count),
   .rsp_loud_found (rsp_ch.loud_found)
);

// ===== test/leading_silence_window_detector_tb.sv =====
module leading_silence_window_detector_tb;

   // Cycles with no handshake on any channel before the run is called hung.
   // The longest legal quiet stretch is the receiver hold-off below.
   localparam int QUIET_LIMIT = 5000;
   // Pause after the last result before a register write or the end; covers
   // the input, squarer and accumulate stages with margin.
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES = 400;
   localparam int WORDS_PER_SETTING = 180;
   localparam logic [lswd_pkg::ThrW-1:0] THR_TOP = 31'd1073741824;

   typedef struct {
      logic signed [lswd_pkg::SampleW-1:0] sample;
      logic                                last;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset;

   lswd_req_if req_if ();
   lswd_rsp_if rsp_if ();
   lswd_csr_if csr_if ();

   leading_silence_window_detector u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #5 clock = ~clock;

   // words waiting for the driver, and reports the predictor expects
   sample_word_type        sample_queue[$];
   lswd_pkg::rsp_word_type expected_reports[$];

   // idle rates in percent, set per phase
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   logic hold_go = 1'b0;
   logic hold_done;
   int hold_left;

   int fail_count = 0;
   int quiet_cycles = 0;

   // ------------------------------------------------------------------
   // Predictor: shadow registers and stream state.
   // ------------------------------------------------------------------
   logic [lswd_pkg::PosW-1:0]  win_len_cfg;
   logic [lswd_pkg::ThrW-1:0]  thr_cfg;
   logic [lswd_pkg::SumW-1:0]  acc_sum;
   logic [lswd_pkg::PosW-1:0]  win_pos;
   logic [lswd_pkg::TrimW-1:0] silent_run;
   logic                       loud_hit;

   // One accepted sample: accumulate its square, judge the window when it
   // fills, and on the last sample emit the report and start a new sound.
   task automatic track_sample(input logic signed [lswd_pkg::SampleW-1:0] s,
                               input logic last);
      logic [lswd_pkg::MagW-1:0]   ext;
      logic [lswd_pkg::MagW-1:0]   mag;
      logic [lswd_pkg::CountW-1:0] span;
      logic [lswd_pkg::CountW-1:0] count;
      logic [lswd_pkg::LimW-1:0]   bound;
      logic [lswd_pkg::TrimW:0]    grown;
      ext = {s[lswd_pkg::SampleW-1], s};
      mag = s[lswd_pkg::SampleW-1] ? -ext : ext;
      acc_sum = acc_sum + lswd_pkg::SumW'(mag) * lswd_pkg::SumW'(mag);
      // a zero length register means a 65536 sample window
      span = (win_len_cfg == '0) ? lswd_pkg::CountW'(1 << lswd_pkg::PosW)
                                 : lswd_pkg::CountW'(win_len_cfg);
      count = lswd_pkg::CountW'(win_pos) + 1'b1;
      // a shortened window closes on the first sample at or past the new length
      if (count >= span) begin
         if (!loud_hit) begin
            bound = lswd_pkg::LimW'(thr_cfg) * lswd_pkg::LimW'(count);
            if (lswd_pkg::LimW'(acc_sum) < bound) begin
               grown = {1'b0, silent_run} + (lswd_pkg::TrimW+1)'(count);
               silent_run = grown[lswd_pkg::TrimW] ? '1 : grown[lswd_pkg::TrimW-1:0];
            end else begin
               loud_hit = 1'b1;
            end
         end
         acc_sum = '0;
         win_pos = '0;
      end else begin
         win_pos = count[lswd_pkg::PosW-1:0];
      end
      if (last) begin
         expected_reports.push_back('{trim_count: silent_run, loud_found: loud_hit});
         acc_sum = '0;
         win_pos = '0;
         silent_run = '0;
         loud_hit = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Sample driver: offers the next queued word, idles at random.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_if.valid  <= 1'b1;
            req_if.sample <= sample_queue[0].sample;
            req_if.last   <= sample_queue[0].last;
            sample_queue.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // every accepted sample goes through the predictor
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         track_sample(req_if.sample, req_if.last);
   end

   // ------------------------------------------------------------------
   // Report receiver: random stalls, plus one long hold-off on request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // report checker: compare with the oldest expected report
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_reports.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
               $display("unexpected report: trim %0d loud %0d",
                        rsp_if.trim_count, rsp_if.loud_found);
         end else begin
            if (rsp_if.trim_count !== expected_reports[0].trim_count ||
                rsp_if.loud_found !== expected_reports[0].loud_found) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("report mismatch: expected trim %0d loud %0d, got trim %0d loud %0d",
                           expected_reports[0].trim_count, expected_reports[0].loud_found,
                           rsp_if.trim_count, rsp_if.loud_found);
            end
            expected_reports.pop_front();
         end
      end
   end

   // watchdog: count cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_word(input logic signed [lswd_pkg::SampleW-1:0] s, input logic last);
      sample_queue.push_back('{sample: s, last: last});
   endtask

   // wait until every word is taken and every report is in, then let the
   // pipeline run empty
   task automatic settle();
      while (sample_queue.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; the shadow copy follows once the write is taken
   task automatic write_reg(input logic [lswd_pkg::CsrIdxW-1:0] idx,
                            input logic [lswd_pkg::CsrDataW-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == lswd_pkg::REG_WINDOW_LENGTH)
         win_len_cfg = value[lswd_pkg::PosW-1:0];
      else
         thr_cfg = value[lswd_pkg::ThrW-1:0];
   endtask

   // One random register setting and a batch of sounds. Most sounds open with
   // whole windows of quiet samples (amplitude tied to the threshold) and go
   // on with full-range samples; some are noise throughout. Sometimes the
   // batch ends inside a sound, so the next setting lands mid-window.
   task automatic random_setting(input int words);
      int amp;
      int wl;
      int n;
      int quiet_len;
      int len;
      int v;
      logic noise;
      longint thr;
      case ($urandom_range(9))
         0:       wl = 1;
         7, 8:    wl = $urandom_range(9, 40);
         9:       wl = $urandom_range(41, 200);
         default: wl = $urandom_range(2, 8);
      endcase
      case ($urandom_range(3))
         0:       amp = $urandom_range(0, 15);
         1:       amp = $urandom_range(16, 400);
         2:       amp = $urandom_range(401, 32767);
         default: amp = $urandom_range(0, 3000);
      endcase
      thr = longint'(amp) * amp + $urandom_range(0, 2 * amp);
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, lswd_pkg::CsrDataW'(wl));
      write_reg(lswd_pkg::REG_THRESHOLD_SQUARE, lswd_pkg::CsrDataW'(thr));
      n = 0;
      while (n < words) begin
         noise = ($urandom_range(4) == 0);
         quiet_len = $urandom_range(0, 4) * wl;
         len = quiet_len + $urandom_range(1, 2 * wl + 3);
         for (int i = 0; i < len; i++) begin
            if (!noise && i < quiet_len)
               v = $urandom_range(0, 2 * amp) - amp;
            else
               v = $urandom();
            push_word(lswd_pkg::SampleW'(v), i == len - 1);
         end
         n += len;
      end
      if ($urandom_range(1) == 1) begin
         len = $urandom_range(1, 2 * wl + 1);
         for (int i = 0; i < len; i++) begin
            v = $urandom_range(0, 2 * amp) - amp;
            push_word(lswd_pkg::SampleW'(v), 1'b0);
         end
      end
      settle();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.index  = lswd_pkg::REG_WINDOW_LENGTH;
      csr_if.data   = '0;
      win_len_cfg = lswd_pkg::WINDOW_LENGTH_RESET;
      thr_cfg     = lswd_pkg::THRESHOLD_SQUARE_RESET;
      acc_sum     = '0;
      win_pos     = '0;
      silent_run  = '0;
      loud_hit    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset values: a short sound never fills a 9600-word window, so
      // nothing is trimmed.
      for (int i = 0; i < 16; i++) push_word(16'sd5, i == 15);
      settle();

      // Directed: window 2, threshold 25.
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd2);
      write_reg(lswd_pkg::REG_THRESHOLD_SQUARE, 32'd25);
      // quiet window, window exactly at threshold (loud), ignored extremes,
      // trailing partial window dropped
      push_word(16'sd4, 1'b0);
      push_word(-16'sd4, 1'b0);
      push_word(16'sd5, 1'b0);
      push_word(-16'sd5, 1'b0);
      push_word(16'sd32767, 1'b0);
      push_word(-16'sd32768, 1'b0);
      push_word(16'sd0, 1'b1);
      // last word completes a quiet window
      push_word(16'sd0, 1'b0);
      push_word(16'sd0, 1'b1);
      // single-word sound, partial window only
      push_word(-16'sd1, 1'b1);
      settle();

      // zero threshold: nothing is quiet
      write_reg(lswd_pkg::REG_THRESHOLD_SQUARE, 32'd0);
      push_word(16'sd7, 1'b0);
      push_word(-16'sd7, 1'b1);
      settle();

      // top threshold, one-word windows: full-scale positive is quiet,
      // full-scale negative sits exactly on the bound
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd1);
      write_reg(lswd_pkg::REG_THRESHOLD_SQUARE, lswd_pkg::CsrDataW'(THR_TOP));
      push_word(16'sd32767, 1'b0);
      push_word(-16'sd32768, 1'b0);
      push_word(16'sd0, 1'b1);
      settle();

      // window shortened mid-window: three words in, length drops to 2, the
      // next word closes a four-word window
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd5);
      write_reg(lswd_pkg::REG_THRESHOLD_SQUARE, 32'd100);
      push_word(16'sd1, 1'b0);
      push_word(16'sd2, 1'b0);
      push_word(16'sd3, 1'b0);
      settle();
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd2);
      push_word(16'sd1, 1'b1);
      settle();

      // zero length register: a 65536-word window that a short sound never
      // closes; then 30 near full-scale words, the length drops to 20 and the
      // next word closes a 31-word window, quiet against the top threshold
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd0);
      write_reg(lswd_pkg::REG_THRESHOLD_SQUARE, lswd_pkg::CsrDataW'(THR_TOP));
      for (int i = 0; i < 12; i++) push_word(-16'sd32768, i == 11);
      for (int i = 0; i < 30; i++) push_word(16'sd32767, 1'b0);
      settle();
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd20);
      push_word(16'sd0, 1'b1);
      settle();

      // longest written window: a short full-scale sound stays partial
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, 32'd65535);
      for (int i = 0; i < 8; i++) push_word(-16'sd32768, i == 7);
      settle();

      // random: sender idles lightly, receiver heavily
      tx_idle_pct = 25;
      rx_idle_pct = 86;
      repeat (3) random_setting(WORDS_PER_SETTING);

      // random: the other way round
      tx_idle_pct = 86;
      rx_idle_pct = 25;
      repeat (3) random_setting(WORDS_PER_SETTING);

      // no idling; the receiver first holds off while one-word sounds keep
      // coming, so reports back up and stall the sample input
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_go = 1'b1;
      for (int i = 0; i < 20; i++) push_word(16'sd3, 1'b1);
      settle();
      repeat (3) random_setting(WORDS_PER_SETTING);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== leading_silence_window_detector.f =====
+incdir+rtl
rtl/lswd_pkg.sv
rtl/lswd_if.sv
rtl/lswd_square.sv
rtl/lswd_accum.sv
rtl/leading_silence_window_detector.sv
rtl/lswd_checker.sv
test/leading_silence_window_detector_tb.sv
